// ----- rtl/core/osd_pkg.sv -----
// ----------------------------------------------------------------------------
// osd_pkg
// Shared types and constants of the object identifier stream decoder.
// ----------------------------------------------------------------------------
package osd_pkg;

  typedef enum logic [2:0] {
    PH_COUNT    = 3'd0,
    PH_PREFIX   = 3'd1,
    PH_INCLUDE  = 3'd2,
    PH_RESERVED = 3'd3,
    PH_SUBIDS   = 3'd4,
    PH_SKIP     = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_TRUNC = 2'd1,
    ST_INCL  = 2'd2
  } status_e;

  localparam int unsigned BurstLen = 5;
  localparam int unsigned BeatW    = 3;

  // one command from the front; burst expands to the five prefix subids
  typedef struct packed {
    logic        burst;
    logic [31:0] value;
    logic        has_value;
    logic        incl;
    status_e     status;
    logic        last;
  } cmd_t;

  typedef struct packed {
    logic [31:0] value;
    logic        has_value;
    logic        incl;
    status_e     status;
    logic        last;
  } res_t;

  // subids 1.3.6.1 ahead of the prefix byte
  function automatic logic [31:0] prefix_subid(input logic [BeatW-1:0] beat);
    logic [31:0] v;
    case (beat)
      3'd0:    v = 32'd1;
      3'd1:    v = 32'd3;
      3'd2:    v = 32'd6;
      3'd3:    v = 32'd1;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

// ----- rtl/core/oid_stream_decoder_unit.sv -----
// A byte's command passes the command queue, then the output register, to the ports.
// Throughput: one byte per cycle unless the queue is full; results leave at one item
// per cycle while popped, and a prefix expansion holds the back end for its five items.
// The command queue (CmdDepth entries) decouples the byte decoder; full stalls input.
// Reset (asynchronous, active low): big-endian order, awaiting count byte, queues empty.
// ----------------------------------------------------------------------------
// oid_stream_decoder_unit
// Streaming AgentX object identifier decoder, queue-style ports on both sides.
// ----------------------------------------------------------------------------
module oid_stream_decoder_unit #(
  parameter int unsigned CmdDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_wdata_i,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  data_byte_i,
  input  logic        end_of_buffer_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] subid_value_o,
  output logic        has_value_o,
  output logic        include_flag_o,
  output logic [1:0]  status_o,
  output logic        last_of_object_o
);

  logic          accept, cmd_valid, cmd_empty, cmd_pop;
  osd_pkg::cmd_t cmd_in, cmd_out;
  osd_pkg::res_t res;

  assign accept = push && !full;

  osd_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .accept_i        (accept),
    .data_byte_i     (data_byte_i),
    .end_of_buffer_i (end_of_buffer_i),
    .cmd_valid_o     (cmd_valid),
    .cmd_o           (cmd_in)
  );

  osd_cmd_fifo #(
    .DEPTH (CmdDepth)
  ) u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_valid),
    .wdata_i (cmd_in),
    .full_o  (full),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_out),
    .empty_o (cmd_empty)
  );

  osd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty_o     (empty),
    .pop_i       (pop),
    .res_o       (res)
  );

  assign subid_value_o    = res.value;
  assign has_value_o      = res.has_value;
  assign include_flag_o   = res.incl;
  assign status_o         = res.status;
  assign last_of_object_o = res.last;

endmodule

// ----- rtl/core/osd_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// osd_cmd_fifo
// Short command queue between the front decoder and the result back end.
// ----------------------------------------------------------------------------
module osd_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  osd_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output osd_pkg::cmd_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  osd_pkg::cmd_t mem_q [DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == CntW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DEPTH))
    else $error("osd_cmd_fifo: count beyond depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("osd_cmd_fifo: push not counted");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("osd_cmd_fifo: pointers apart while empty");
`endif

endmodule

// ----- rtl/core/osd_front.sv -----
// ----------------------------------------------------------------------------
// osd_front
// Header and subid byte decoder; turns each byte into at most one command.
// ----------------------------------------------------------------------------
module osd_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic          cfg_wdata_i,
  input  logic          accept_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_buffer_i,
  output logic          cmd_valid_o,
  output osd_pkg::cmd_t cmd_o
);

  osd_pkg::phase_e phase_q, phase_d;
  logic [7:0]  left_q, left_d, left_dec;
  logic [1:0]  pos_q, pos_d, lane;
  logic [31:0] word_q, word_d, word_new;
  logic [7:0]  prefix_q, prefix_d;
  logic        incl_q, incl_d;
  logic        big_q;
  logic [4:0]  shift;

  assign lane     = big_q ? ~pos_q : pos_q;
  assign shift    = {lane, 3'b000};
  assign word_new = ((pos_q == 2'd0) ? 32'd0 : word_q) | ({24'd0, data_byte_i} << shift);
  assign left_dec = left_q - 8'd1;

  always_comb begin
    phase_d  = phase_q;
    left_d   = left_q;
    pos_d    = pos_q;
    word_d   = word_q;
    prefix_d = prefix_q;
    incl_d   = incl_q;
    cmd_valid_o     = 1'b0;
    cmd_o.burst     = 1'b0;
    cmd_o.value     = 32'd0;
    cmd_o.has_value = 1'b0;
    cmd_o.incl      = incl_q;
    cmd_o.status    = osd_pkg::ST_OK;
    cmd_o.last      = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        osd_pkg::PH_PREFIX: begin
          prefix_d = data_byte_i;
          if (end_of_buffer_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = osd_pkg::ST_TRUNC;
            cmd_o.last   = 1'b1;
            phase_d      = osd_pkg::PH_COUNT;
          end else begin
            phase_d = osd_pkg::PH_INCLUDE;
          end
        end
        osd_pkg::PH_INCLUDE: begin
          if (end_of_buffer_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = osd_pkg::ST_TRUNC;
            cmd_o.last   = 1'b1;
            phase_d      = osd_pkg::PH_COUNT;
          end else if (data_byte_i > 8'd1) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = osd_pkg::ST_INCL;
            cmd_o.last   = 1'b1;
            phase_d      = osd_pkg::PH_SKIP;
          end else begin
            incl_d  = data_byte_i[0];
            phase_d = osd_pkg::PH_RESERVED;
          end
        end
        osd_pkg::PH_RESERVED: begin
          if (end_of_buffer_i && left_q != 8'd0) begin
            cmd_valid_o  = 1'b1;
            cmd_o.status = osd_pkg::ST_TRUNC;
            cmd_o.last   = 1'b1;
            phase_d      = osd_pkg::PH_COUNT;
          end else begin
            if (prefix_q != 8'd0) begin
              cmd_valid_o     = 1'b1;
              cmd_o.burst     = 1'b1;
              cmd_o.value     = {24'd0, prefix_q};
              cmd_o.has_value = 1'b1;
              cmd_o.last      = (left_q == 8'd0);
            end else if (left_q == 8'd0) begin
              cmd_valid_o = 1'b1;
              cmd_o.last  = 1'b1;
            end
            if (left_q == 8'd0) begin
              phase_d = osd_pkg::PH_COUNT;
            end else begin
              pos_d   = 2'd0;
              word_d  = 32'd0;
              phase_d = osd_pkg::PH_SUBIDS;
            end
          end
        end
        osd_pkg::PH_SUBIDS: begin
          word_d = word_new;
          if (pos_q == 2'd3) begin
            left_d = left_dec;
            pos_d  = 2'd0;
            cmd_valid_o = 1'b1;
            if (left_dec == 8'd0) begin
              cmd_o.value     = word_new;
              cmd_o.has_value = 1'b1;
              cmd_o.last      = 1'b1;
              phase_d         = osd_pkg::PH_COUNT;
            end else if (end_of_buffer_i) begin
              cmd_o.status = osd_pkg::ST_TRUNC;
              cmd_o.last   = 1'b1;
              phase_d      = osd_pkg::PH_COUNT;
            end else begin
              cmd_o.value     = word_new;
              cmd_o.has_value = 1'b1;
            end
          end else begin
            pos_d = pos_q + 2'd1;
            if (end_of_buffer_i) begin
              cmd_valid_o  = 1'b1;
              cmd_o.status = osd_pkg::ST_TRUNC;
              cmd_o.last   = 1'b1;
              pos_d        = 2'd0;
              phase_d      = osd_pkg::PH_COUNT;
            end
          end
        end
        osd_pkg::PH_SKIP: begin
          if (end_of_buffer_i) begin
            phase_d = osd_pkg::PH_COUNT;
          end
        end
        default: begin
          // count byte
          left_d = data_byte_i;
          incl_d = 1'b0;
          if (end_of_buffer_i) begin
            cmd_valid_o  = 1'b1;
            cmd_o.incl   = 1'b0;
            cmd_o.status = osd_pkg::ST_TRUNC;
            cmd_o.last   = 1'b1;
            phase_d      = osd_pkg::PH_COUNT;
          end else begin
            phase_d = osd_pkg::PH_PREFIX;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= osd_pkg::PH_COUNT;
      left_q   <= 8'd0;
      pos_q    <= 2'd0;
      prefix_q <= 8'd0;
      incl_q   <= 1'b0;
      big_q    <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      left_q   <= left_d;
      pos_q    <= pos_d;
      prefix_q <= prefix_d;
      incl_q   <= incl_d;
      if (cfg_we_i) begin
        big_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && phase_q == osd_pkg::PH_SKIP && end_of_buffer_i |=> phase_q == osd_pkg::PH_COUNT)
    else $error("osd_front: skip not left at buffer end");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != osd_pkg::PH_SUBIDS |-> pos_q == 2'd0)
    else $error("osd_front: byte position stale outside subids");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == osd_pkg::PH_SUBIDS |-> left_q != 8'd0)
    else $error("osd_front: subid phase with nothing left");
`endif

endmodule

// ----- rtl/core/osd_back.sv -----
// ----------------------------------------------------------------------------
// osd_back
// Expands queued commands into result items and holds the output register.
// ----------------------------------------------------------------------------
module osd_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  osd_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output osd_pkg::res_t res_o
);

  localparam logic [osd_pkg::BeatW-1:0] LastBeat = osd_pkg::BeatW'(osd_pkg::BurstLen - 1);

  logic [osd_pkg::BeatW-1:0] beat_q, beat_d;
  logic          out_valid_q, out_valid_d;
  osd_pkg::res_t out_q, out_d;
  logic          adv, take, final_beat;

  assign adv        = !out_valid_q || pop_i;
  assign take       = adv && !cmd_empty_i;
  assign final_beat = !cmd_i.burst || (beat_q == LastBeat);
  assign cmd_pop_o  = take && final_beat;
  assign empty_o    = !out_valid_q;
  assign res_o      = out_q;

  always_comb begin
    beat_d      = beat_q;
    out_valid_d = out_valid_q;
    out_d.value     = cmd_i.value;
    out_d.has_value = cmd_i.has_value;
    out_d.incl      = cmd_i.incl;
    out_d.status    = cmd_i.status;
    out_d.last      = cmd_i.last;
    if (cmd_i.burst && beat_q != LastBeat) begin
      out_d.value = osd_pkg::prefix_subid(beat_q);
      out_d.last  = 1'b0;
    end
    if (take) begin
      out_valid_d = 1'b1;
      beat_d      = final_beat ? '0 : beat_q + 1'b1;
    end else if (adv) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      beat_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      beat_q      <= beat_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= out_d;
    end
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_q != '0 |-> !cmd_empty_i && cmd_i.burst)
    else $error("osd_back: burst beat without burst command");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != osd_pkg::ST_OK |-> !out_q.has_value && out_q.last)
    else $error("osd_back: malformed error item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_q.has_value |-> out_q.value == 32'd0)
    else $error("osd_back: value on item without subid");
`endif

endmodule
